// File: sv/tgr_pkg.sv
// Shared types and constants for the tracking grid resampler.
// Used by tgr_ctrl, tgr_datapath and tracking_grid_resampler.
package tgr_pkg;

  localparam int unsigned POS_FRAC_BITS = 8;

  localparam logic [30:0] MASK31       = 31'h7FFF_FFFF;
  localparam logic [23:0] POS_INVALID  = 24'(-(32'sd1 <<< POS_FRAC_BITS));
  localparam logic [15:0] HEAD_INVALID = 16'hFFC0;   // -64
  localparam logic signed [17:0] HEAD_HALF = 18'sd11520;
  localparam logic signed [25:0] HEAD_FULL = 26'sd23040;
  localparam logic [30:0] STEP_RESET   = 31'd400;

  // divider runs one quotient bit per step
  localparam int unsigned QUO_W = 25;

  // input commands
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_END    = 2'd1;
  localparam logic [1:0] CMD_CONT   = 2'd2;

  // drain modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_PENDING = 2'd1;
  localparam logic [1:0] MODE_ENDING  = 2'd2;
  localparam logic [1:0] MODE_DONE    = 2'd3;

  // register indexes
  localparam logic [1:0] REG_STEP = 2'd0;
  localparam logic [1:0] REG_END  = 2'd1;
  localparam logic [1:0] REG_GAP  = 2'd2;

  // interpolation lanes
  localparam logic [1:0] LANE_X = 2'd0;
  localparam logic [1:0] LANE_Y = 2'd1;
  localparam logic [1:0] LANE_H = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [30:0]        stamp;
    logic signed [23:0] in_x;
    logic signed [23:0] in_y;
    logic signed [15:0] in_heading;
  } in_beat_t;

  typedef struct packed {
    logic [30:0]        grid_time;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [15:0] out_heading;
    logic               last;
    logic               more_pending;
  } out_beat_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  idx;
    logic [30:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [30:0] grid_step;
    logic [30:0] grid_end;
    logic [30:0] max_gap;
  } cfg_regs_t;

  typedef struct packed {
    logic load_sample;
    logic set_end;
    logic burst_init;
    logic lane_init;
    logic mark_invalid;
    logic mul;
    logic prep;
    logic div_step;
    logic lane_store;
    logic advance;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       has_point;
    logic       pt_ok;
    logic       div_done;
    logic       lane_last;
  } dp_stat_t;

endpackage

// File: sv/tgr_datapath.sv
// Datapath: sample state, grid counter, config registers and the shared
// multiply / serial divide interpolation unit. Depends on tgr_pkg.
module tgr_datapath import tgr_pkg::*; #(
  parameter int unsigned MAX_BURST = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  input  in_beat_t  in_data_i,
  input  cfg_wr_t   cfg_wr_i,
  output cfg_regs_t cfg_o,
  output dp_stat_t  stat_o,
  output out_beat_t out_data_o
);

  localparam int unsigned BW = $clog2(MAX_BURST + 1);
  localparam int unsigned PW = 32 + BW;

  logic [30:0] step_q, end_q, gap_q, next_grid_q;
  logic [1:0]  mode_q;
  logic        have_cur_q, have_prev_q;
  logic [30:0] prev_stamp_q, cur_stamp_q;
  logic signed [23:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic signed [15:0] prev_h_q, cur_h_q;
  logic [BW-1:0] n_q;
  logic          pend_q;
  logic [1:0]    lane_q;
  logic          neg_q;
  logic [55:0]   prod_q;
  logic [32:0]   rem_q;
  logic [QUO_W-1:0] low_q, quo_q;
  logic [4:0]    cnt_q;
  logic signed [23:0] res_x_q, res_y_q;
  logic signed [15:0] res_h_q;

  logic [30:0] limit, ng_next, t_val, dt_val;
  logic [31:0] ng_sum;
  logic        lt_limit, pt_ok;
  logic signed [17:0] dh, dwrap;
  logic signed [25:0] diff, base;
  logic [24:0] mag;
  logic [57:0] num;
  logic [32:0] trial, dvs;
  logic signed [25:0] res, res_h;
  logic [PW-1:0] burst_end;

  assign limit = (mode_q == MODE_PENDING && cur_stamp_q < end_q) ? cur_stamp_q : end_q;
  assign lt_limit = next_grid_q < limit;
  assign ng_sum  = {1'b0, next_grid_q} + {1'b0, step_q};
  assign ng_next = ng_sum[31] ? MASK31 : ng_sum[30:0];
  assign t_val   = next_grid_q - prev_stamp_q;
  assign dt_val  = cur_stamp_q - prev_stamp_q;
  assign burst_end = PW'(next_grid_q) + PW'(step_q) * PW'(MAX_BURST);

  assign pt_ok = have_cur_q && have_prev_q && (next_grid_q < cur_stamp_q)
              && (prev_stamp_q <= next_grid_q) && (cur_stamp_q > prev_stamp_q)
              && (dt_val <= gap_q) && (prev_x_q != POS_INVALID)
              && (cur_x_q != POS_INVALID) && (prev_h_q != HEAD_INVALID)
              && (cur_h_q != HEAD_INVALID);

  // heading difference wrapped into +-180 degrees
  always_comb begin
    dh = 18'(cur_h_q) - 18'(prev_h_q);
    priority if (dh < -HEAD_HALF) begin
      dwrap = dh + 18'(HEAD_FULL);
    end else if (dh > HEAD_HALF) begin
      dwrap = dh - 18'(HEAD_FULL);
    end else begin
      dwrap = dh;
    end
  end

  always_comb begin
    unique case (lane_q)
      LANE_X: begin
        diff = 26'(cur_x_q) - 26'(prev_x_q);
        base = 26'(prev_x_q);
      end
      LANE_Y: begin
        diff = 26'(cur_y_q) - 26'(prev_y_q);
        base = 26'(prev_y_q);
      end
      default: begin
        diff = 26'(dwrap);
        base = 26'(prev_h_q);
      end
    endcase
    mag = diff[25] ? 25'(-diff) : diff[24:0];
  end

  assign num   = {1'b0, prod_q, 1'b0} + 58'(dt_val);
  assign dvs   = {1'b0, dt_val, 1'b0};
  assign trial = {rem_q[31:0], low_q[QUO_W-1]};

  always_comb begin
    res = neg_q ? base - 26'(quo_q) : base + 26'(quo_q);
    res_h = res;
    if (res_h < 0) begin
      res_h = res_h + HEAD_FULL;
    end
    if (res_h > HEAD_FULL) begin
      res_h = res_h - HEAD_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= STEP_RESET;
      end_q        <= MASK31;
      gap_q        <= MASK31;
      next_grid_q  <= STEP_RESET;
      mode_q       <= MODE_IDLE;
      have_cur_q   <= 1'b0;
      have_prev_q  <= 1'b0;
      prev_stamp_q <= '0;
      cur_stamp_q  <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_h_q     <= '0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      cur_h_q      <= '0;
      n_q          <= '0;
      pend_q       <= 1'b0;
      lane_q       <= LANE_X;
      cnt_q        <= '0;
    end else begin
      if (cfg_wr_i.we) begin
        unique case (cfg_wr_i.idx)
          REG_STEP: begin
            step_q      <= (cfg_wr_i.data == '0) ? 31'd1 : cfg_wr_i.data;
            next_grid_q <= (cfg_wr_i.data == '0) ? 31'd1 : cfg_wr_i.data;
          end
          REG_END: end_q <= cfg_wr_i.data;
          REG_GAP: gap_q <= cfg_wr_i.data;
          default: ;
        endcase
      end
      if (cmd_i.load_sample) begin
        prev_stamp_q <= cur_stamp_q;
        prev_x_q     <= cur_x_q;
        prev_y_q     <= cur_y_q;
        prev_h_q     <= cur_h_q;
        have_prev_q  <= have_cur_q;
        have_cur_q   <= 1'b1;
        cur_stamp_q  <= in_data_i.stamp;
        cur_x_q      <= in_data_i.in_x;
        cur_y_q      <= in_data_i.in_y;
        cur_h_q      <= in_data_i.in_heading;
        mode_q       <= MODE_PENDING;
      end
      if (cmd_i.set_end) begin
        mode_q <= MODE_ENDING;
      end
      if (cmd_i.burst_init) begin
        n_q    <= '0;
        pend_q <= burst_end < PW'(limit);
      end
      if (cmd_i.lane_init) begin
        lane_q <= LANE_X;
      end
      if (cmd_i.prep) begin
        cnt_q <= 5'(QUO_W);
      end
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 5'd1;
      end
      if (cmd_i.lane_store) begin
        lane_q <= lane_q + 2'd1;
      end
      if (cmd_i.advance) begin
        next_grid_q <= ng_next;
        n_q         <= n_q + BW'(1);
      end
      if (cmd_i.finish && !lt_limit) begin
        mode_q <= (mode_q == MODE_PENDING) ? MODE_IDLE : MODE_DONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 56'(mag) * 56'(t_val);
      neg_q  <= diff[25];
    end
    if (cmd_i.prep) begin
      rem_q <= num[57:QUO_W];
      low_q <= num[QUO_W-1:0];
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      if (trial >= dvs) begin
        rem_q <= trial - dvs;
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd_i.lane_store) begin
      unique case (lane_q)
        LANE_X:  res_x_q <= res[23:0];
        LANE_Y:  res_y_q <= res[23:0];
        default: res_h_q <= res_h[15:0];
      endcase
    end
    if (cmd_i.mark_invalid) begin
      res_x_q <= POS_INVALID;
      res_y_q <= POS_INVALID;
      res_h_q <= HEAD_INVALID;
    end
  end

  assign cfg_o.grid_step = step_q;
  assign cfg_o.grid_end  = end_q;
  assign cfg_o.max_gap   = gap_q;

  assign stat_o.mode      = mode_q;
  assign stat_o.has_point = lt_limit && (n_q != BW'(MAX_BURST));
  assign stat_o.pt_ok     = pt_ok;
  assign stat_o.div_done  = (cnt_q == '0);
  assign stat_o.lane_last = (lane_q == LANE_H);

  assign out_data_o.grid_time    = next_grid_q;
  assign out_data_o.out_x        = res_x_q;
  assign out_data_o.out_y        = res_y_q;
  assign out_data_o.out_heading  = res_h_q;
  assign out_data_o.last         = (n_q == BW'(MAX_BURST - 1)) || !(ng_next < limit);
  assign out_data_o.more_pending = pend_q;

endmodule

// File: sv/tgr_ctrl.sv
// Controller state machine: command decode, burst loop and lane sequencing.
// Depends on tgr_pkg; drives tgr_datapath through dp_cmd_t.
module tgr_ctrl import tgr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BURST = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_PREP  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       acc;

  assign acc         = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (in_cmd_i)
            CMD_SAMPLE: begin
              if (stat_i.mode == MODE_IDLE) begin
                cmd_o.load_sample = 1'b1;
                state_d = S_BURST;
              end
            end
            CMD_END: begin
              if (stat_i.mode != MODE_DONE) begin
                cmd_o.set_end = 1'b1;
                state_d = S_BURST;
              end
            end
            CMD_CONT: begin
              if (stat_i.mode == MODE_PENDING || stat_i.mode == MODE_ENDING) begin
                state_d = S_BURST;
              end
            end
            default: ;
          endcase
        end
      end
      S_BURST: begin
        cmd_o.burst_init = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!stat_i.has_point) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.pt_ok) begin
          cmd_o.lane_init = 1'b1;
          state_d = S_MUL;
        end else begin
          cmd_o.mark_invalid = 1'b1;
          state_d = S_OUT;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.lane_store = 1'b1;
        state_d = stat_i.lane_last ? S_OUT : S_MUL;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          cmd_o.advance = 1'b1;
          state_d = S_CHECK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/tracking_grid_resampler.sv
// Top level of the tracking grid resampler: APB register port, controller
// and datapath. Depends on tgr_pkg, tgr_ctrl and tgr_datapath.
//
// Input beats (in_valid_i / in_stall_o) carry a command and a tracking sample;
// output beats (out_valid_o / out_stall_i) carry one interpolated grid point.
// A beat moves when valid is high and stall is low.
// One input item is taken at a time: in_stall_o stays high from the accept
// until the last grid point of the item has been delivered.
// Per item: a burst set-up, then per grid point a check; an invalid point goes
// straight to output, a valid one runs three lanes (each one multiply
// and a 25-step restoring divide on the shared unit). The receiver may hold a
// result with out_stall_i high. A stalled result simply holds.
// At most MAX_BURST points per item; continue commands drain the rest.
// Reset restores grid_step 400, grid_end and max_gap to 2^31-1, clears the
// sample history and restarts the grid. Registers: grid_step at 0x0,
// grid_end at 0x4, max_gap at 0x8; write them only while idle.
module tracking_grid_resampler import tgr_pkg::*; #(
  parameter int unsigned MAX_BURST = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t   dp_cmd;
  dp_stat_t  dp_stat;
  cfg_wr_t   cfg_wr;
  cfg_regs_t cfg;

  assign pready      = 1'b1;
  assign cfg_wr.we   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[3:2];
  assign cfg_wr.data = pwdata[30:0];

  always_comb begin
    unique case (paddr[3:2])
      REG_STEP: prdata = {1'b0, cfg.grid_step};
      REG_END:  prdata = {1'b0, cfg.grid_end};
      REG_GAP:  prdata = {1'b0, cfg.max_gap};
      default:  prdata = '0;
    endcase
  end

  tgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  tgr_datapath #(
    .MAX_BURST (MAX_BURST)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .in_data_i  (in_data_i),
    .cfg_wr_i   (cfg_wr),
    .cfg_o      (cfg),
    .stat_o     (dp_stat),
    .out_data_o (out_data_o)
  );

endmodule

// File: test/tb.sv
// Self-checking testbench for tracking_grid_resampler: directed and random
// sample streams, in-file interpolation predictor, APB register phases.
// Depends on tgr_pkg and the resampler RTL.
`timescale 1ns / 1ps

module tb;
  import tgr_pkg::*;

  localparam int unsigned BURST_MAX = 64;
  localparam longint T_MAX = 64'd2147483647;
  localparam longint POS_BAD = -256;
  localparam longint HDG_BAD = -64;
  localparam int unsigned WATCHDOG = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  in_beat_t    in_data = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  out_beat_t   out_data_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tracking_grid_resampler #(.MAX_BURST(BURST_MAX)) u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o, .in_data_i(in_data),
    .out_valid_o, .out_stall_i(out_stall), .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tracker state mirrored for prediction
  longint r_step, r_end, r_gap;
  bit     have_cur, have_prev;
  longint p_stamp, p_x, p_y, p_h, c_stamp, c_x, c_y, c_h, nxt_grid;
  logic [1:0] mode;

  in_beat_t  feed_q[$];
  out_beat_t exp_points[$];
  int unsigned errors = 0;
  bit     no_idle = 1'b0;
  longint gen_t = 0;

  function automatic longint lerp(longint a, longint b, longint t, longint dt);
    longint d, mag, q;
    d = b - a;
    mag = (d < 0) ? -d : d;
    q = (2 * mag * t + dt) / (2 * dt);
    return (d < 0) ? a - q : a + q;
  endfunction

  function automatic out_beat_t grid_point(longint g);
    out_beat_t p;
    longint x, y, h, t, dt, d;
    bit ok;
    x = POS_BAD; y = POS_BAD; h = HDG_BAD;
    ok = have_cur && have_prev && g < c_stamp && p_stamp <= g && c_stamp > p_stamp &&
         (c_stamp - p_stamp) <= r_gap && p_x != POS_BAD && c_x != POS_BAD &&
         p_h != HDG_BAD && c_h != HDG_BAD;
    if (ok) begin
      t = g - p_stamp;
      dt = c_stamp - p_stamp;
      d = c_h - p_h;
      x = lerp(p_x, c_x, t, dt);
      y = lerp(p_y, c_y, t, dt);
      if (d < -11520) d += 23040;
      else if (d > 11520) d -= 23040;
      h = lerp(p_h, p_h + d, t, dt);
      if (h < 0) h += 23040;
      if (h > 23040) h -= 23040;
    end
    p.grid_time = g[30:0];
    p.out_x = x[23:0];
    p.out_y = y[23:0];
    p.out_heading = h[15:0];
    p.last = 1'b0;
    p.more_pending = 1'b0;
    return p;
  endfunction

  function automatic void emit_points();
    out_beat_t burst[$];
    longint lim;
    bit more;
    lim = r_end;
    if (mode == MODE_PENDING && c_stamp < lim) lim = c_stamp;
    while (burst.size() < BURST_MAX && nxt_grid < lim) begin
      burst.push_back(grid_point(nxt_grid));
      nxt_grid += r_step;
      if (nxt_grid > T_MAX) nxt_grid = T_MAX;
    end
    more = nxt_grid < lim;
    if (!more) mode = (mode == MODE_PENDING) ? MODE_IDLE : MODE_DONE;
    foreach (burst[k]) begin
      burst[k].last = (k == burst.size() - 1);
      burst[k].more_pending = more;
      exp_points.push_back(burst[k]);
    end
  endfunction

  function automatic void resample_step(in_beat_t b);
    case (b.cmd)
      CMD_SAMPLE: begin
        if (mode == MODE_IDLE) begin
          p_stamp = c_stamp; p_x = c_x; p_y = c_y; p_h = c_h;
          have_prev = have_cur;
          have_cur = 1'b1;
          c_stamp = longint'(b.stamp);
          c_x = longint'($signed(b.in_x));
          c_y = longint'($signed(b.in_y));
          c_h = longint'($signed(b.in_heading));
          mode = MODE_PENDING;
          emit_points();
        end
      end
      CMD_END: begin
        if (mode != MODE_DONE) begin
          mode = MODE_ENDING;
          emit_points();
        end
      end
      CMD_CONT: if (mode == MODE_PENDING || mode == MODE_ENDING) emit_points();
      default: ;
    endcase
  endfunction

  task automatic send(logic [1:0] cmd, longint stamp, longint x, longint y, longint h);
    in_beat_t b;
    b.cmd = cmd;
    b.stamp = stamp[30:0];
    b.in_x = x[23:0];
    b.in_y = y[23:0];
    b.in_heading = h[15:0];
    resample_step(b);
    feed_q.push_back(b);
  endtask

  function automatic longint rand_pos();
    if ($urandom_range(0, 9) == 0) return POS_BAD;
    return longint'($signed(24'($urandom)));
  endfunction

  function automatic longint rand_hdg();
    if ($urandom_range(0, 9) == 0) return HDG_BAD;
    return longint'($urandom_range(0, 23040));
  endfunction

  task automatic drain();
    while (mode == MODE_PENDING || mode == MODE_ENDING)
      send(CMD_CONT, $urandom, rand_pos(), rand_pos(), rand_hdg());
  endtask

  // mostly well-formed sample streams, with continues when points wait
  task automatic random_items(int n);
    int r;
    longint inc;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if ((mode == MODE_PENDING || mode == MODE_ENDING) && r < 75) begin
        send(CMD_CONT, $urandom, rand_pos(), rand_pos(), rand_hdg());
      end else if (r < 4) begin
        send(2'd3, $urandom, rand_pos(), rand_pos(), rand_hdg());
      end else begin
        if (r < 10) begin
          gen_t -= $urandom_range(0, 2 * r_step < T_MAX ? 2 * r_step : 1 << 30);
          if (gen_t < 0) gen_t = 0;
        end else begin
          inc = (r_step < (1 << 29)) ? $urandom_range(0, 3 * r_step)
                                     : $urandom_range(0, 1 << 30);
          gen_t += inc;
          if (gen_t > T_MAX) gen_t = T_MAX;
        end
        send(CMD_SAMPLE, gen_t, rand_pos(), rand_pos(), rand_hdg());
      end
    end
    drain();
  endtask

  task automatic wait_idle();
    while (feed_q.size() != 0 || in_valid || exp_points.size() != 0) @(posedge clk_i);
    // an item with no results may still be in flight
    repeat (100) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, longint value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value[31:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    value &= T_MAX;
    case (idx)
      REG_STEP: begin
        r_step = (value == 0) ? 1 : value;
        nxt_grid = r_step;
        gen_t = 0;
      end
      REG_END: r_end = value;
      REG_GAP: r_gap = value;
      default: ;
    endcase
  endtask

  // driver
  int unsigned feed_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      feed_gap = 0;
    end else begin
      if (in_valid && !in_stall_o) feed_gap = no_idle ? 0 : $urandom_range(0, 6);
      if (!in_valid || !in_stall_o) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          in_data <= feed_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // monitor
  int unsigned hold = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (exp_points.size() == 0) begin
          report("unexpected beat", out_data_o.grid_time, 0);
        end else begin
          e = exp_points.pop_front();
          if (out_data_o.grid_time !== e.grid_time)
            report("grid_time", out_data_o.grid_time, e.grid_time);
          if (out_data_o.out_x !== e.out_x) report("out_x", out_data_o.out_x, e.out_x);
          if (out_data_o.out_y !== e.out_y) report("out_y", out_data_o.out_y, e.out_y);
          if (out_data_o.out_heading !== e.out_heading)
            report("out_heading", out_data_o.out_heading, e.out_heading);
          if (out_data_o.last !== e.last) report("last", out_data_o.last, e.last);
          if (out_data_o.more_pending !== e.more_pending)
            report("more_pending", out_data_o.more_pending, e.more_pending);
        end
        hold = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with work outstanding but no beat moving
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (feed_q.size() == 0 && !in_valid && exp_points.size() == 0)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    r_step = 400; r_end = T_MAX; r_gap = T_MAX;
    have_cur = 0; have_prev = 0;
    p_stamp = 0; p_x = 0; p_y = 0; p_h = 0;
    c_stamp = 0; c_x = 0; c_y = 0; c_h = 0;
    nxt_grid = r_step;
    mode = MODE_IDLE;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle continue, unknown command, first sample, extremes, wraps
    send(CMD_CONT, 0, 0, 0, 0);
    send(2'd3, T_MAX, -1, -1, -1);
    send(CMD_SAMPLE, 1000, 0, 0, 0);
    send(CMD_SAMPLE, 2000, 8388607, -8388608, 23040);
    send(CMD_SAMPLE, 3000, -8388608, 8388607, 0);
    send(CMD_SAMPLE, 4000, 256, 0, 22400);
    send(CMD_SAMPLE, 5000, 512, 0, 640);
    send(CMD_SAMPLE, 6000, POS_BAD, POS_BAD, 640);
    send(CMD_SAMPLE, 7000, 0, 0, HDG_BAD);
    send(CMD_SAMPLE, 7000, 0, 0, 100);
    send(CMD_SAMPLE, 6500, 0, 0, 100);
    send(CMD_SAMPLE, 8000, 0, 0, 100);
    // long segment overflows one burst; a sample while pending is dropped
    send(CMD_SAMPLE, 36000, 0, 0, 0);
    send(CMD_SAMPLE, 40000, 5, 5, 5);
    send(CMD_CONT, 0, 0, 0, 0);
    // half-way ties round away from zero
    send(CMD_SAMPLE, 36800, 1, -1, 1);
    send(CMD_SAMPLE, 37600, 0, 0, 0);
    gen_t = 37600;
    drain();
    wait_idle();

    // fine grid, a gap limit that some segments exceed
    no_idle = 1'b1;
    reg_write(REG_STEP, 0);
    reg_write(REG_GAP, 2);
    reg_write(REG_END, 200000);
    random_items(60);
    wait_idle();

    no_idle = 1'b0;
    reg_write(REG_STEP, 50);
    reg_write(REG_GAP, $urandom_range(50, 150));
    random_items(120);
    wait_idle();

    // coarse grid across the whole stamp range, then the saturating step
    reg_write(REG_STEP, 32'h4000_0001);
    reg_write(REG_GAP, T_MAX);
    reg_write(REG_END, T_MAX);
    random_items(30);
    wait_idle();
    reg_write(REG_STEP, T_MAX);
    random_items(10);
    wait_idle();

    reg_write(REG_STEP, $urandom_range(20, 300));
    reg_write(REG_GAP, 0);
    random_items(20);
    wait_idle();
    reg_write(REG_GAP, $urandom_range(r_step, 3 * r_step));
    random_items(80);
    wait_idle();

    // end of data: remaining points invalid, later commands do nothing
    reg_write(REG_END, gen_t + 100 * r_step);
    send(CMD_SAMPLE, gen_t + r_step, 100, 100, 100);
    drain();
    send(CMD_END, 0, 0, 0, 0);
    send(CMD_END, 0, 0, 0, 0);
    drain();
    send(CMD_END, 0, 0, 0, 0);
    send(CMD_SAMPLE, T_MAX, 0, 0, 0);
    send(CMD_CONT, 0, 0, 0, 0);
    wait_idle();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
